FILE: rtl/core/albs_pkg.sv
// ----------------------------------------------------------------------------
// albs_pkg
// Types, constants and microcode store for the element store search engine.
// ----------------------------------------------------------------------------
package albs_pkg;

  localparam int WordW = 32;
  localparam int OpW   = 2;
  localparam int PosW  = 5;
  localparam int UpcW  = 5;

  typedef enum logic [OpW-1:0] {
    OpClear  = 2'd0,
    OpAppend = 2'd1,
    OpLinear = 2'd2,
    OpSorted = 2'd3
  } op_e;

  typedef enum logic [3:0] {
    ActNop      = 4'd0,
    ActClear    = 4'd1,
    ActAppend   = 4'd2,
    ActLinInit  = 4'd3,
    ActLinStep  = 4'd4,
    ActSortInit = 4'd5,
    ActLoadA    = 4'd6,
    ActCmp      = 4'd7,
    ActWrJ      = 4'd8,
    ActWrI      = 4'd9,
    ActNextJ    = 4'd10,
    ActNextI    = 4'd11,
    ActBinInit  = 4'd12,
    ActMid      = 4'd13,
    ActBinStep  = 4'd14,
    ActResult   = 4'd15
  } act_e;

  typedef enum logic [3:0] {
    CondNone        = 4'd0,
    CondAlways      = 4'd1,
    CondDispatch    = 4'd2,
    CondEmpty       = 4'd3,
    CondLinMore     = 4'd4,
    CondStay        = 4'd5,
    CondNoSwap      = 4'd6,
    CondNotRowEnd   = 4'd7,
    CondNotSortDone = 4'd8,
    CondSortSmall   = 4'd9,
    CondBinDone     = 4'd10,
    CondNotEq       = 4'd11
  } cond_e;

  typedef enum logic [2:0] {
    RdI    = 3'd0,
    RdINxt = 3'd1,
    RdJ    = 3'd2,
    RdJNxt = 3'd3,
    RdMid  = 3'd4
  } rsel_e;

  typedef enum logic [1:0] {
    HoldNone = 2'd0,
    HoldIn   = 2'd1,
    HoldOut  = 2'd2
  } hold_e;

  typedef struct packed {
    act_e            act;
    cond_e           cond;
    rsel_e           rsel;
    hold_e           hold;
    logic [UpcW-1:0] target;
  } ctrl_t;

  localparam logic [UpcW-1:0] StIdle    = 5'd0;
  localparam logic [UpcW-1:0] StClear   = 5'd1;
  localparam logic [UpcW-1:0] StAppend  = 5'd2;
  localparam logic [UpcW-1:0] StLinInit = 5'd3;
  localparam logic [UpcW-1:0] StLinRd   = 5'd4;
  localparam logic [UpcW-1:0] StLinCmp  = 5'd5;
  localparam logic [UpcW-1:0] StLinEnd  = 5'd6;
  localparam logic [UpcW-1:0] StSrtInit = 5'd7;
  localparam logic [UpcW-1:0] StSrtRdI  = 5'd8;
  localparam logic [UpcW-1:0] StSrtRdJ  = 5'd9;
  localparam logic [UpcW-1:0] StSrtCmp  = 5'd10;
  localparam logic [UpcW-1:0] StSrtDec  = 5'd11;
  localparam logic [UpcW-1:0] StSrtWrJ  = 5'd12;
  localparam logic [UpcW-1:0] StSrtWrI  = 5'd13;
  localparam logic [UpcW-1:0] StSrtAdv  = 5'd14;
  localparam logic [UpcW-1:0] StSrtRow  = 5'd15;
  localparam logic [UpcW-1:0] StBinInit = 5'd16;
  localparam logic [UpcW-1:0] StBinTest = 5'd17;
  localparam logic [UpcW-1:0] StBinRd   = 5'd18;
  localparam logic [UpcW-1:0] StBinCmp  = 5'd19;
  localparam logic [UpcW-1:0] StResult  = 5'd20;

  function automatic ctrl_t ucode_rom(input logic [UpcW-1:0] addr);
    ctrl_t w;
    w.act    = ActNop;
    w.cond   = CondNone;
    w.rsel   = RdI;
    w.hold   = HoldNone;
    w.target = StIdle;
    case (addr)
      StIdle: begin
        w.hold = HoldIn;
        w.cond = CondDispatch;
      end
      StClear: begin
        w.act  = ActClear;
        w.cond = CondAlways;
      end
      StAppend: begin
        w.act  = ActAppend;
        w.cond = CondAlways;
      end
      StLinInit: begin
        w.act    = ActLinInit;
        w.cond   = CondEmpty;
        w.target = StResult;
      end
      StLinRd: begin
        w.rsel = RdI;
      end
      StLinCmp: begin
        w.act    = ActLinStep;
        w.rsel   = RdINxt;
        w.cond   = CondLinMore;
        w.target = StLinCmp;
      end
      StLinEnd: begin
        w.cond   = CondAlways;
        w.target = StResult;
      end
      StSrtInit: begin
        w.act    = ActSortInit;
        w.cond   = CondSortSmall;
        w.target = StBinInit;
      end
      StSrtRdI: begin
        w.rsel = RdI;
      end
      StSrtRdJ: begin
        w.act  = ActLoadA;
        w.rsel = RdJ;
      end
      StSrtCmp: begin
        w.act    = ActCmp;
        w.rsel   = RdJNxt;
        w.cond   = CondStay;
        w.target = StSrtCmp;
      end
      StSrtDec: begin
        w.cond   = CondNoSwap;
        w.target = StSrtRow;
      end
      StSrtWrJ: begin
        w.act = ActWrJ;
      end
      StSrtWrI: begin
        w.act = ActWrI;
      end
      StSrtAdv: begin
        w.act    = ActNextJ;
        w.rsel   = RdI;
        w.cond   = CondNotRowEnd;
        w.target = StSrtRdJ;
      end
      StSrtRow: begin
        w.act    = ActNextI;
        w.cond   = CondNotSortDone;
        w.target = StSrtRdI;
      end
      StBinInit: begin
        w.act = ActBinInit;
      end
      StBinTest: begin
        w.act    = ActMid;
        w.cond   = CondBinDone;
        w.target = StResult;
      end
      StBinRd: begin
        w.rsel = RdMid;
      end
      StBinCmp: begin
        w.act    = ActBinStep;
        w.cond   = CondNotEq;
        w.target = StBinTest;
      end
      StResult: begin
        w.act  = ActResult;
        w.hold = HoldOut;
        w.cond = CondAlways;
      end
      default: begin
        w.cond = CondAlways;
      end
    endcase
    return w;
  endfunction

endpackage

FILE: rtl/core/albs_req_if.sv
// ----------------------------------------------------------------------------
// albs_req_if
// Request channel: operation code and word, valid/ready transfer.
// ----------------------------------------------------------------------------
interface albs_req_if;
  logic                               valid;
  logic                               ready;
  logic        [albs_pkg::OpW-1:0]    operation;
  logic signed [albs_pkg::WordW-1:0]  value;

  modport source (output valid, output operation, output value, input ready);
  modport sink   (input valid, input operation, input value, output ready);
endinterface

FILE: rtl/core/albs_rsp_if.sv
// ----------------------------------------------------------------------------
// albs_rsp_if
// Response channel: search hit flag and index, valid/ready transfer.
// ----------------------------------------------------------------------------
interface albs_rsp_if;
  logic                        valid;
  logic                        ready;
  logic                        found;
  logic [albs_pkg::PosW-1:0]   position;

  modport source (output valid, output found, output position, input ready);
  modport sink   (input valid, input found, input position, output ready);
endinterface

FILE: rtl/core/array_linear_and_binary_search.sv
// ----------------------------------------------------------------------------
// array_linear_and_binary_search
// Word store with append, clear, linear search and sort-then-binary search.
// ----------------------------------------------------------------------------
// Usage:
//   req_i carries an operation and a signed 32-bit word. Clear and append
//   return nothing; linear and sorted search return one transfer on rsp_o
//   with found and position (position is 0 when not found).
//   One item at a time: req_i.ready is high only while the sequencer waits
//   at its idle step. Sorted search: an exchange sort over the single memory
//   read port, then binary search.
//   The result sits in an output register; the sequencer waits at its
//   result step only if an earlier result has not yet been taken.
//   Reset empties the store (count zero) and drops any pending result.
//   The store contents are not cleared.
// ----------------------------------------------------------------------------
module array_linear_and_binary_search #(
  parameter int DEPTH = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  albs_req_if.sink          req_i,
  albs_rsp_if.source        rsp_o
);

  localparam int IdxW = $clog2(DEPTH);
  localparam int CntW = $clog2(DEPTH + 1);
  localparam int WordW = albs_pkg::WordW;
  localparam int PosW = albs_pkg::PosW;
  localparam int UpcW = albs_pkg::UpcW;

  albs_pkg::ctrl_t ctrl;

  logic [UpcW-1:0]  upc_q, upc_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic [IdxW-1:0]  i_q, i_d, j_q, j_d, mid_q, mid_d;
  logic [CntW-1:0]  lo_q, lo_d, hip_q, hip_d;
  logic [WordW-1:0] a_q, a_d, b_q, b_d, key_q, key_d;
  logic             found_q, found_d;
  logic [IdxW-1:0]  pos_q, pos_d;
  logic             rsp_valid_q, rsp_valid_d;
  logic             rsp_found_q, rsp_found_d;
  logic [PosW-1:0]  rsp_pos_q, rsp_pos_d;

  logic [WordW-1:0] mem_q [DEPTH];
  logic [WordW-1:0] rd_q;
  logic [IdxW-1:0]  rd_addr;
  logic             wr_en;
  logic [IdxW-1:0]  wr_addr;
  logic [WordW-1:0] wr_data;

  logic             go, take, out_free;
  logic             eq, key_lt, rd_lt_a, b_lt_a;
  logic             row_end, lin_last, sort_more;
  logic             stay;
  logic [CntW:0]    mid_sum;
  logic [IdxW+PosW-1:0] pos_wide;

  assign ctrl = albs_pkg::ucode_rom(upc_q);

  assign out_free  = !rsp_valid_q || rsp_o.ready;
  assign eq        = rd_q == key_q;
  assign key_lt    = $signed(key_q) < $signed(rd_q);
  assign rd_lt_a   = $signed(rd_q) < $signed(a_q);
  assign b_lt_a    = $signed(b_q) < $signed(a_q);
  assign row_end   = ((CntW+1)'(j_q) + (CntW+1)'(1)) == (CntW+1)'(cnt_q);
  assign lin_last  = ((CntW+1)'(i_q) + (CntW+1)'(1)) == (CntW+1)'(cnt_q);
  assign sort_more = ((CntW+1)'(i_q) + (CntW+1)'(2)) < (CntW+1)'(cnt_q);
  assign stay      = !rd_lt_a && !row_end;
  assign mid_sum   = (CntW+1)'(lo_q) + (CntW+1)'(hip_q) - (CntW+1)'(1);
  assign pos_wide  = (IdxW+PosW)'(pos_q);

  assign req_i.ready    = (upc_q == albs_pkg::StIdle);
  assign rsp_o.valid    = rsp_valid_q;
  assign rsp_o.found    = rsp_found_q;
  assign rsp_o.position = rsp_pos_q;

  always_comb begin
    case (ctrl.hold)
      albs_pkg::HoldIn:  go = req_i.valid;
      albs_pkg::HoldOut: go = out_free;
      default:           go = 1'b1;
    endcase
  end

  always_comb begin
    case (ctrl.cond)
      albs_pkg::CondAlways:      take = 1'b1;
      albs_pkg::CondEmpty:       take = (cnt_q == '0);
      albs_pkg::CondLinMore:     take = !eq && !lin_last;
      albs_pkg::CondStay:        take = stay;
      albs_pkg::CondNoSwap:      take = !b_lt_a;
      albs_pkg::CondNotRowEnd:   take = !row_end;
      albs_pkg::CondNotSortDone: take = sort_more;
      albs_pkg::CondSortSmall:   take = (cnt_q <= CntW'(1));
      albs_pkg::CondBinDone:     take = (lo_q >= hip_q);
      albs_pkg::CondNotEq:       take = !eq;
      default:                   take = 1'b0;
    endcase
  end

  always_comb begin
    if (!go) begin
      upc_d = upc_q;
    end else if (ctrl.cond == albs_pkg::CondDispatch) begin
      case (albs_pkg::op_e'(req_i.operation))
        albs_pkg::OpClear:  upc_d = albs_pkg::StClear;
        albs_pkg::OpAppend: upc_d = albs_pkg::StAppend;
        albs_pkg::OpLinear: upc_d = albs_pkg::StLinInit;
        albs_pkg::OpSorted: upc_d = albs_pkg::StSrtInit;
        default:            upc_d = albs_pkg::StIdle;
      endcase
    end else if (take) begin
      upc_d = ctrl.target;
    end else begin
      upc_d = upc_q + UpcW'(1);
    end
  end

  always_comb begin
    case (ctrl.rsel)
      albs_pkg::RdINxt: rd_addr = i_q + IdxW'(1);
      albs_pkg::RdJ:    rd_addr = j_q;
      albs_pkg::RdJNxt: rd_addr = j_q + IdxW'(1);
      albs_pkg::RdMid:  rd_addr = mid_q;
      default:          rd_addr = i_q;
    endcase
  end

  always_comb begin
    cnt_d       = cnt_q;
    i_d         = i_q;
    j_d         = j_q;
    mid_d       = mid_q;
    lo_d        = lo_q;
    hip_d       = hip_q;
    a_d         = a_q;
    b_d         = b_q;
    key_d       = key_q;
    found_d     = found_q;
    pos_d       = pos_q;
    rsp_valid_d = rsp_valid_q && !rsp_o.ready;
    rsp_found_d = rsp_found_q;
    rsp_pos_d   = rsp_pos_q;
    wr_en       = 1'b0;
    wr_addr     = i_q;
    wr_data     = b_q;

    if (req_i.valid && req_i.ready) begin
      key_d = req_i.value;
    end

    if (go) begin
      case (ctrl.act)
        albs_pkg::ActClear: begin
          cnt_d = '0;
        end
        albs_pkg::ActAppend: begin
          if (cnt_q < CntW'(DEPTH)) begin
            wr_en   = 1'b1;
            wr_addr = cnt_q[IdxW-1:0];
            wr_data = key_q;
            cnt_d   = cnt_q + CntW'(1);
          end
        end
        albs_pkg::ActLinInit: begin
          i_d     = '0;
          found_d = 1'b0;
          pos_d   = '0;
        end
        albs_pkg::ActLinStep: begin
          if (eq) begin
            found_d = 1'b1;
            pos_d   = i_q;
          end else begin
            i_d = i_q + IdxW'(1);
          end
        end
        albs_pkg::ActSortInit: begin
          i_d = '0;
          j_d = IdxW'(1);
        end
        albs_pkg::ActLoadA: begin
          a_d = rd_q;
        end
        albs_pkg::ActCmp: begin
          b_d = rd_q;
          if (stay) begin
            j_d = j_q + IdxW'(1);
          end
        end
        albs_pkg::ActWrJ: begin
          wr_en   = 1'b1;
          wr_addr = j_q;
          wr_data = a_q;
        end
        albs_pkg::ActWrI: begin
          wr_en   = 1'b1;
          wr_addr = i_q;
          wr_data = b_q;
          a_d     = b_q;
        end
        albs_pkg::ActNextJ: begin
          j_d = j_q + IdxW'(1);
        end
        albs_pkg::ActNextI: begin
          i_d = i_q + IdxW'(1);
          j_d = i_q + IdxW'(2);
        end
        albs_pkg::ActBinInit: begin
          lo_d    = '0;
          hip_d   = cnt_q;
          found_d = 1'b0;
          pos_d   = '0;
        end
        albs_pkg::ActMid: begin
          mid_d = mid_sum[IdxW:1];
        end
        albs_pkg::ActBinStep: begin
          if (eq) begin
            found_d = 1'b1;
            pos_d   = mid_q;
          end else if (key_lt) begin
            hip_d = CntW'(mid_q);
          end else begin
            lo_d = CntW'(mid_q) + CntW'(1);
          end
        end
        albs_pkg::ActResult: begin
          rsp_valid_d = 1'b1;
          rsp_found_d = found_q;
          rsp_pos_d   = pos_wide[PosW-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upc_q       <= albs_pkg::StIdle;
      cnt_q       <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      upc_q       <= upc_d;
      cnt_q       <= cnt_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    i_q         <= i_d;
    j_q         <= j_d;
    mid_q       <= mid_d;
    lo_q        <= lo_d;
    hip_q       <= hip_d;
    a_q         <= a_d;
    b_q         <= b_d;
    key_q       <= key_d;
    found_q     <= found_d;
    pos_q       <= pos_d;
    rsp_found_q <= rsp_found_d;
    rsp_pos_q   <= rsp_pos_d;
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    rd_q <= mem_q[rd_addr];
  end

  a_upc_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    upc_q <= albs_pkg::StResult)
    else $error("sequencer left its program");

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(DEPTH))
    else $error("element count beyond depth");

  a_rsp_origin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rsp_valid_q) |-> $past(upc_q) == albs_pkg::StResult)
    else $error("response raised outside result step");

  a_accept_leaves_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_i.valid && req_i.ready) |=> upc_q != albs_pkg::StIdle)
    else $error("accepted transfer not dispatched");

endmodule

FILE: tb/tb_array_linear_and_binary_search.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_array_linear_and_binary_search
// Self-checking bench for the word store search engine. A directed burst
// (empty store, extremes, duplicates, misses, clear) is followed by random
// clear/append/search groups. A behavioral store model predicts each search
// result, and the results are checked in order under random stalls on both
// channels.
// ----------------------------------------------------------------------------
module tb_array_linear_and_binary_search;

  localparam int Depth        = 32;
  localparam int ItemTarget   = 750;
  localparam int TailItems    = 100;
  localparam int LongHoldAt   = 300;
  localparam int LongHoldLen  = 400;
  localparam int QuietLimit   = 20000;
  localparam int SettleCycles = 40;

  typedef struct {
    albs_pkg::op_e                     op;
    logic signed [albs_pkg::WordW-1:0] value;
    bit                                drain;
  } req_item_t;

  typedef struct packed {
    logic                      found;
    logic [albs_pkg::PosW-1:0] position;
  } search_res_t;

  logic clk_i;
  logic rst_ni;

  albs_req_if req_bus ();
  albs_rsp_if rsp_bus ();

  array_linear_and_binary_search #(
    .DEPTH (Depth)
  ) dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_bus),
    .rsp_o  (rsp_bus)
  );

  req_item_t                         pending_q[$];
  search_res_t                       expected_q[$];
  logic signed [albs_pkg::WordW-1:0] shadow_words[Depth];
  int                                shadow_count = 0;
  int                                n_total      = 0;
  int                                n_accepted   = 0;
  int                                n_errors     = 0;

  task automatic report_mismatch(input string what);
    n_errors++;
    $display("%0t mismatch: %s", $time, what);
  endtask

  // Updates the shadow store; returns 1 when the operation yields a result.
  function automatic bit apply_op(input albs_pkg::op_e op,
                                  input logic signed [albs_pkg::WordW-1:0] key,
                                  output search_res_t res);
    int                                lo;
    int                                hi;
    int                                mid;
    logic signed [albs_pkg::WordW-1:0] tmp;
    res = '0;
    case (op)
      albs_pkg::OpClear: begin
        shadow_count = 0;
        return 1'b0;
      end
      albs_pkg::OpAppend: begin
        if (shadow_count < Depth) begin
          shadow_words[shadow_count] = key;
          shadow_count++;
        end
        return 1'b0;
      end
      albs_pkg::OpLinear: begin
        for (int m = 0; m < shadow_count; m++) begin
          if (shadow_words[m] == key) begin
            res.found    = 1'b1;
            res.position = albs_pkg::PosW'(m);
            break;
          end
        end
      end
      default: begin
        for (int i = 0; i < shadow_count; i++) begin
          for (int j = i + 1; j < shadow_count; j++) begin
            if (shadow_words[j] < shadow_words[i]) begin
              tmp             = shadow_words[j];
              shadow_words[j] = shadow_words[i];
              shadow_words[i] = tmp;
            end
          end
        end
        lo = 0;
        hi = shadow_count - 1;
        while (lo <= hi) begin
          mid = (lo + hi) / 2;
          if (shadow_words[mid] == key) begin
            res.found    = 1'b1;
            res.position = albs_pkg::PosW'(mid);
            break;
          end else if (key < shadow_words[mid]) begin
            hi = mid - 1;
          end else begin
            lo = mid + 1;
          end
        end
      end
    endcase
    return 1'b1;
  endfunction

  // flavor 0: small range with many duplicates, 1: extremes, else full range
  function automatic logic signed [albs_pkg::WordW-1:0] draw_word(input int flavor);
    case (flavor)
      0: return int'($urandom_range(0, 16)) - 8;
      1: begin
        case ($urandom_range(0, 3))
          0: return 32'sh7FFFFFFF;
          1: return 32'sh80000000;
          2: return -1;
          default: return 0;
        endcase
      end
      default: return $urandom;
    endcase
  endfunction

  task automatic push_item(input albs_pkg::op_e op,
                           input logic signed [albs_pkg::WordW-1:0] v,
                           input bit drain = 1'b0);
    req_item_t it;
    it.op    = op;
    it.value = v;
    it.drain = drain;
    pending_q.push_back(it);
  endtask

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    logic signed [albs_pkg::WordW-1:0] w;
    logic signed [albs_pkg::WordW-1:0] group_words[$];
    albs_pkg::op_e                     sop;
    int                                n_app;
    int                                n_srch;
    int                                flavor;
    int                                r;
    bit                                drain_next;
    bit                                first_group;

    rst_ni <= 1'b0;

    // empty store, extremes, duplicates, misses, clear
    push_item(albs_pkg::OpLinear, 0);
    push_item(albs_pkg::OpSorted, 32'sh80000000);
    push_item(albs_pkg::OpAppend, 32'sh7FFFFFFF);
    push_item(albs_pkg::OpAppend, 32'sh80000000);
    push_item(albs_pkg::OpAppend, -1);
    push_item(albs_pkg::OpAppend, 5);
    push_item(albs_pkg::OpAppend, 0);
    push_item(albs_pkg::OpAppend, 5);
    push_item(albs_pkg::OpAppend, 1);
    push_item(albs_pkg::OpLinear, 32'sh80000000);
    push_item(albs_pkg::OpLinear, 5);
    push_item(albs_pkg::OpLinear, 32'sh7FFFFFFF);
    push_item(albs_pkg::OpLinear, 2);
    push_item(albs_pkg::OpSorted, 5);
    push_item(albs_pkg::OpSorted, 32'sh80000000);
    push_item(albs_pkg::OpSorted, 32'sh7FFFFFFF);
    push_item(albs_pkg::OpSorted, -2);
    push_item(albs_pkg::OpLinear, -1);
    push_item(albs_pkg::OpClear, -1);
    push_item(albs_pkg::OpLinear, 5);
    push_item(albs_pkg::OpSorted, 5);

    first_group = 1'b1;
    while (pending_q.size() < ItemTarget) begin
      drain_next = first_group || ($urandom_range(0, 9) == 0);
      if (first_group || $urandom_range(0, 9) != 0) begin
        push_item(albs_pkg::OpClear, $urandom, drain_next);
        drain_next = 1'b0;
        group_words.delete();
      end
      flavor = $urandom_range(0, 2);
      r      = $urandom_range(0, 99);
      if (first_group)  n_app = 34;
      else if (r < 80)  n_app = $urandom_range(0, 8);
      else if (r < 92)  n_app = $urandom_range(9, 20);
      else              n_app = $urandom_range(32, 36);
      repeat (n_app) begin
        w = draw_word(flavor);
        group_words.push_back(w);
        push_item(albs_pkg::OpAppend, w, drain_next);
        drain_next = 1'b0;
      end
      n_srch = $urandom_range(1, 6);
      repeat (n_srch) begin
        if (group_words.size() > 0 && $urandom_range(0, 9) < 6) begin
          w = group_words[$urandom_range(0, group_words.size() - 1)];
        end else begin
          w = draw_word($urandom_range(0, 2));
        end
        if ($urandom_range(0, 1) != 0) begin
          sop = albs_pkg::OpLinear;
        end else begin
          sop = albs_pkg::OpSorted;
        end
        push_item(sop, w, drain_next);
        drain_next = 1'b0;
      end
      if ($urandom_range(0, 9) == 0) begin
        push_item(albs_pkg::op_e'($urandom_range(0, 3)), $urandom);
      end
      first_group = 1'b0;
    end
    n_total = pending_q.size();

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (n_accepted < n_total || expected_q.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
    if (n_errors == 0) begin
      $display("PASS array_linear_and_binary_search");
    end else begin
      $display("FAIL array_linear_and_binary_search");
    end
    $finish;
  end

  // request driver
  req_item_t offer;
  bit        offering;
  int        send_gap;
  bit        send_calm;

  always @(posedge clk_i or negedge rst_ni) begin
    search_res_t res;
    if (!rst_ni) begin
      offer.op          = albs_pkg::OpClear;
      offer.value       = '0;
      offer.drain       = 1'b0;
      offering          = 1'b0;
      send_gap          = 0;
      send_calm         = 1'b0;
      req_bus.valid     <= 1'b0;
      req_bus.operation <= albs_pkg::OpClear;
      req_bus.value     <= '0;
    end else begin
      if (req_bus.valid && req_bus.ready) begin
        if (apply_op(offer.op, offer.value, res)) begin
          expected_q.push_back(res);
        end
        n_accepted++;
        offering = 1'b0;
      end
      if (!offering) begin
        if ($urandom_range(0, 199) == 0) send_calm = !send_calm;
        if (send_gap > 0) begin
          send_gap--;
        end else if (pending_q.size() > 0 &&
                     !(pending_q[0].drain && pending_q.size() > TailItems &&
                       expected_q.size() != 0)) begin
          if (!send_calm && pending_q.size() > TailItems && $urandom_range(0, 5) == 0) begin
            send_gap = $urandom_range(1, 10);
          end else begin
            offer    = pending_q.pop_front();
            offering = 1'b1;
          end
        end
      end
      req_bus.valid     <= offering;
      req_bus.operation <= offer.op;
      req_bus.value     <= offer.value;
    end
  end

  // response monitor and checker
  int rsp_hold;
  bit long_hold_done;
  bit recv_calm;

  always @(posedge clk_i or negedge rst_ni) begin
    search_res_t want;
    if (!rst_ni) begin
      rsp_hold       = 0;
      long_hold_done = 1'b0;
      recv_calm      = 1'b0;
      rsp_bus.ready  <= 1'b0;
    end else begin
      if (rsp_bus.valid && rsp_bus.ready) begin
        if (expected_q.size() == 0) begin
          report_mismatch($sformatf("unexpected transfer found=%0b position=%0d",
                                    rsp_bus.found, rsp_bus.position));
        end else begin
          want = expected_q.pop_front();
          if (rsp_bus.found !== want.found) begin
            report_mismatch($sformatf("found %0b, want %0b", rsp_bus.found, want.found));
          end
          if (rsp_bus.position !== want.position) begin
            report_mismatch($sformatf("position %0d, want %0d",
                                      rsp_bus.position, want.position));
          end
        end
      end
      if ($urandom_range(0, 199) == 0) recv_calm = !recv_calm;
      if (rsp_hold > 0) begin
        rsp_hold--;
      end else if (!long_hold_done && n_accepted >= LongHoldAt) begin
        rsp_hold       = LongHoldLen;
        long_hold_done = 1'b1;
      end else if (!recv_calm && n_accepted + TailItems < n_total &&
                   $urandom_range(0, 5) == 0) begin
        rsp_hold = $urandom_range(1, 10);
      end
      rsp_bus.ready <= (rsp_hold == 0);
    end
  end

  // watchdog: cycles without any transfer
  int quiet = 0;

  always @(posedge clk_i) begin
    if (!rst_ni || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
      quiet <= 0;
    end else if (quiet >= QuietLimit) begin
      $display("FAIL array_linear_and_binary_search");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

endmodule
